@@ rtl/nhd_pkg.sv @@
// shared types and constants for the normalized histogram distance block
package nhd_pkg;

    localparam int COUNT_W     = 16;
    localparam int CFG_W       = 8;
    localparam int Q_W         = 17;
    localparam int BINS_FLOOR  = 2;
    localparam logic [CFG_W-1:0] BINS_RESET = 8'd100;

    typedef struct packed {
        logic mul_sel;
        logic x_load;
        logic acc_clr;
        logic acc_en;
        logic first_bin;
        logic fin;
    } t_acc_ctl;

endpackage

@@ rtl/normalized_histogram_distance_top.sv @@
// top level of the normalized histogram distance block
//
// input words carry one bin pair (first_count, second_count) on a valid/ready
// channel. each accepted word is stored in an on-chip bin memory and added to
// the two running sums. input ready stays high while loading, so words can
// follow back to back. the word that completes the configured bin count
// starts the compute pass: one shared multiplier forms both cross products
// of each bin, so each bin steps through read, two multiplies, compare and
// accumulate. a 17-step serial divider then yields the Q1.16 fraction; it
// is skipped when both histograms are empty. input ready is low from the
// last bin of a pass until its result word enters the output register.
// a result sits in an output register; the next pass loads while it waits.
// if a new result is due while the old one is still not taken, the block
// holds it and stays not ready until the receiver takes the old word.
// the configuration channel takes a new bin count at any cycle; write it only
// when the block is idle. reset (synchronous, active low) sets the bin count
// to 100 and clears the pass position and sums.
module normalized_histogram_distance_top #(
    parameter int MAX_BINS = 128
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [nhd_pkg::COUNT_W-1:0]  i_first_count,
    input  logic [nhd_pkg::COUNT_W-1:0]  i_second_count,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [nhd_pkg::Q_W-1:0]      o_distance_q16,
    output logic                         o_no_area,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [nhd_pkg::CFG_W-1:0]    i_cfg_data
);
    import nhd_pkg::*;

    localparam int IW     = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int CW     = $clog2(MAX_BINS + 1);
    localparam int SUM_W  = COUNT_W + IW;
    localparam int PROD_W = COUNT_W + SUM_W;
    localparam int AREA_W = PROD_W + IW + 1;

    typedef enum logic [8:0] {
        S_LOAD  = 9'b000000001,
        S_READ  = 9'b000000010,
        S_MULA  = 9'b000000100,
        S_MULB  = 9'b000001000,
        S_ACC   = 9'b000010000,
        S_FIN   = 9'b000100000,
        S_CHECK = 9'b001000000,
        S_DIV   = 9'b010000000,
        S_OUT   = 9'b100000000
    } t_state;

    t_state                 r_state;
    t_state                 n_state;
    logic [CFG_W-1:0]       r_bins_in_use;
    logic [IW-1:0]          r_bin_index;
    logic [IW-1:0]          n_bin_index;
    logic [SUM_W-1:0]       r_first_sum;
    logic [SUM_W-1:0]       r_second_sum;
    logic [IW-1:0]          r_i;
    logic [2*COUNT_W-1:0]   r_mem [MAX_BINS];
    logic [2*COUNT_W-1:0]   r_rd_data;
    logic                   r_none;
    logic                   r_out_valid;
    logic [Q_W-1:0]         r_dist;
    logic                   r_no_area;

    logic [15:0]            cfg_wide;
    logic [CW-1:0]          eff_bins;
    logic [CW-1:0]          load_next;
    logic                   load_last;
    logic [CW-1:0]          calc_next;
    logic                   calc_last;
    logic                   in_accept;
    logic                   out_free;
    t_acc_ctl               acc_ctl;
    logic [AREA_W-1:0]      area_min;
    logic [AREA_W-1:0]      area_max;
    logic                   div_start;
    logic                   div_done;
    logic [Q_W-1:0]         div_quot;

    always_comb begin
        cfg_wide = 16'(r_bins_in_use);
        if (cfg_wide < 16'(BINS_FLOOR)) begin
            eff_bins = CW'(BINS_FLOOR);
        end else if (cfg_wide > 16'(MAX_BINS)) begin
            eff_bins = CW'(MAX_BINS);
        end else begin
            eff_bins = CW'(cfg_wide);
        end
        load_next = CW'(r_bin_index) + CW'(1);
        load_last = (load_next >= eff_bins);
        calc_next = CW'(r_i) + CW'(1);
        calc_last = (calc_next == eff_bins);
        in_accept = i_in_valid && o_in_ready;
        out_free  = !r_out_valid || i_out_ready;
        n_bin_index = load_last ? '0 : load_next[IW-1:0];
    end

    assign o_in_ready  = (r_state == S_LOAD);
    assign o_cfg_ready = 1'b1;

    // sequencer
    always_comb begin
        n_state           = r_state;
        acc_ctl           = '0;
        div_start         = 1'b0;
        acc_ctl.acc_clr   = in_accept && load_last;
        case (r_state)
            S_LOAD: begin
                if (in_accept && load_last) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_MULA;
            end
            S_MULA: begin
                n_state = S_MULB;
            end
            S_MULB: begin
                acc_ctl.mul_sel = 1'b1;
                acc_ctl.x_load  = 1'b1;
                n_state         = S_ACC;
            end
            S_ACC: begin
                acc_ctl.acc_en    = 1'b1;
                acc_ctl.first_bin = (r_i == '0);
                n_state           = calc_last ? S_FIN : S_READ;
            end
            S_FIN: begin
                acc_ctl.fin = 1'b1;
                n_state     = S_CHECK;
            end
            S_CHECK: begin
                if (area_max == '0) begin
                    n_state = S_OUT;
                end else begin
                    div_start = 1'b1;
                    n_state   = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_LOAD;
            r_bins_in_use <= BINS_RESET;
            r_bin_index   <= '0;
            r_first_sum   <= '0;
            r_second_sum  <= '0;
            r_i           <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_bins_in_use <= i_cfg_data;
            end
            if (in_accept) begin
                r_bin_index  <= n_bin_index;
                r_first_sum  <= r_first_sum + SUM_W'(i_first_count);
                r_second_sum <= r_second_sum + SUM_W'(i_second_count);
                r_i          <= '0;
            end
            if (r_state == S_ACC) begin
                r_i <= calc_next[IW-1:0];
            end
            if (r_state == S_FIN) begin
                r_first_sum  <= '0;
                r_second_sum <= '0;
            end
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // bin memory
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_mem[r_bin_index] <= {i_first_count, i_second_count};
        end
        r_rd_data <= r_mem[r_i];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_CHECK) begin
            r_none <= (area_max == '0);
        end
        if (r_state == S_OUT && out_free) begin
            r_dist    <= r_none ? '0 : div_quot;
            r_no_area <= r_none;
        end
    end

    nhd_mul_acc #(
        .SUM_W  (SUM_W),
        .AREA_W (AREA_W)
    ) u_mul_acc (
        .i_clk      (i_clk),
        .i_ctl      (acc_ctl),
        .i_count_a  (r_rd_data[2*COUNT_W-1:COUNT_W]),
        .i_count_b  (r_rd_data[COUNT_W-1:0]),
        .i_sum_a    (r_first_sum),
        .i_sum_b    (r_second_sum),
        .o_area_min (area_min),
        .o_area_max (area_max)
    );

    nhd_div #(
        .AREA_W (AREA_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (area_max - area_min),
        .i_den   (area_max),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign o_out_valid    = r_out_valid;
    assign o_distance_q16 = r_dist;
    assign o_no_area      = r_no_area;

    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("sequencer state not one-hot");

    a_no_area_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_no_area) |-> (o_distance_q16 == '0))
        else $error("distance nonzero with no area");

    a_dist_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!o_distance_q16[Q_W-1] || o_distance_q16[Q_W-2:0] == '0))
        else $error("distance above one");

    a_last_starts_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && load_last) |=> (r_state == S_READ && r_i == '0))
        else $error("last bin did not start the compute pass");

endmodule

@@ rtl/nhd_mul_acc.sv @@
// shared multiplier, min/max compare and area accumulators
module nhd_mul_acc #(
    parameter int SUM_W  = 23,
    parameter int AREA_W = 47
) (
    input  logic                         i_clk,
    input  nhd_pkg::t_acc_ctl            i_ctl,
    input  logic [nhd_pkg::COUNT_W-1:0]  i_count_a,
    input  logic [nhd_pkg::COUNT_W-1:0]  i_count_b,
    input  logic [SUM_W-1:0]             i_sum_a,
    input  logic [SUM_W-1:0]             i_sum_b,
    output logic [AREA_W-1:0]            o_area_min,
    output logic [AREA_W-1:0]            o_area_max
);
    import nhd_pkg::*;

    localparam int PROD_W = COUNT_W + SUM_W;
    localparam int ACC_W  = AREA_W - 1;

    logic [SUM_W-1:0]   da;
    logic [SUM_W-1:0]   db;
    logic [COUNT_W-1:0] mul_a;
    logic [SUM_W-1:0]   mul_b;
    logic [PROD_W-1:0]  lo;
    logic [PROD_W-1:0]  hi;

    logic [PROD_W-1:0]  r_prod;
    logic [PROD_W-1:0]  r_x;
    logic [ACC_W-1:0]   r_smin;
    logic [ACC_W-1:0]   r_smax;
    logic [PROD_W-1:0]  r_fmin;
    logic [PROD_W-1:0]  r_fmax;
    logic [AREA_W-1:0]  r_amin;
    logic [AREA_W-1:0]  r_amax;

    always_comb begin
        da    = (i_sum_a == '0) ? SUM_W'(1) : i_sum_a;
        db    = (i_sum_b == '0) ? SUM_W'(1) : i_sum_b;
        mul_a = i_ctl.mul_sel ? i_count_b : i_count_a;
        mul_b = i_ctl.mul_sel ? da : db;
        lo    = (r_x <= r_prod) ? r_x : r_prod;
        hi    = (r_x <= r_prod) ? r_prod : r_x;
    end

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
        if (i_ctl.x_load) begin
            r_x <= r_prod;
        end
        if (i_ctl.acc_clr) begin
            r_smin <= '0;
            r_smax <= '0;
        end else if (i_ctl.acc_en) begin
            r_smin <= r_smin + ACC_W'(lo);
            r_smax <= r_smax + ACC_W'(hi);
        end
        if (i_ctl.acc_en && i_ctl.first_bin) begin
            r_fmin <= lo;
            r_fmax <= hi;
        end
        // trapezoid sum with zero bin appended: 2*sum - v[0]
        if (i_ctl.fin) begin
            r_amin <= {r_smin, 1'b0} - AREA_W'(r_fmin);
            r_amax <= {r_smax, 1'b0} - AREA_W'(r_fmax);
        end
    end

    assign o_area_min = r_amin;
    assign o_area_max = r_amax;

endmodule

@@ rtl/nhd_div.sv @@
// serial restoring divider giving floor(num * 2^16 / den) for num <= den
module nhd_div #(
    parameter int AREA_W = 47
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [AREA_W-1:0]        i_num,
    input  logic [AREA_W-1:0]        i_den,
    output logic                     o_done,
    output logic [nhd_pkg::Q_W-1:0]  o_quot
);
    import nhd_pkg::*;

    localparam int CNT_W = $clog2(Q_W);

    logic [AREA_W:0]    trial;
    logic [AREA_W:0]    diff;
    logic               take;

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [AREA_W:0]    r_rem;
    logic [AREA_W-1:0]  r_den;
    logic [Q_W-1:0]     r_q;

    always_comb begin
        trial = (r_cnt == '0) ? r_rem : {r_rem[AREA_W-1:0], 1'b0};
        take  = (trial >= {1'b0, r_den});
        diff  = trial - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(Q_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {1'b0, i_num};
            r_den <= i_den;
            r_q   <= '0;
        end else if (r_busy) begin
            r_rem <= take ? diff : trial;
            r_q   <= {r_q[Q_W-2:0], take};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider started while busy");

    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_cnt != '0) |-> (r_rem < {1'b0, r_den}))
        else $error("partial remainder not below divisor");

    a_done_ends_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !r_busy)
        else $error("done raised while still busy");

endmodule

@@ bench/tb_normalized_histogram_distance_top.sv @@
// testbench for the normalized histogram distance block: predicted results versus bin-pair traffic
module tb_normalized_histogram_distance_top;

    import nhd_pkg::*;

    localparam int BIN_CAP            = 128;
    localparam int BIN_IW             = $clog2(BIN_CAP);
    localparam int RANDOM_ITEM_TARGET = 700;
    localparam int RESULT_HOLD_CYCLES = 600;
    localparam int SETTLE_CYCLES      = 8;
    localparam int END_CYCLES         = 4 * BIN_CAP + 40;
    localparam int WATCHDOG_LIMIT     = 6000;
    localparam int REPORT_LIMIT       = 10;

    typedef enum int {
        FILL_RANDOM,
        FILL_SMALL,
        FILL_FIRST_EMPTY,
        FILL_SECOND_EMPTY,
        FILL_SAME,
        FILL_SPARSE
    } t_fill;

    typedef struct {
        bit [Q_W-1:0] distance;
        bit           no_area;
    } t_distance_word;

    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               i_in_valid     = 1'b0;
    logic               o_in_ready;
    logic [COUNT_W-1:0] i_first_count  = '0;
    logic [COUNT_W-1:0] i_second_count = '0;
    logic               o_out_valid;
    logic               i_out_ready    = 1'b0;
    logic [Q_W-1:0]     o_distance_q16;
    logic               o_no_area;
    logic               i_cfg_valid    = 1'b0;
    logic               o_cfg_ready;
    logic [CFG_W-1:0]   i_cfg_data     = '0;

    // predictor state
    bit [COUNT_W-1:0] first_mem [BIN_CAP];
    bit [COUNT_W-1:0] second_mem [BIN_CAP];
    bit [7:0]         bin_pos      = '0;
    bit [22:0]        first_total  = '0;
    bit [22:0]        second_total = '0;
    bit [CFG_W-1:0]   bins_setting = BINS_RESET;

    t_distance_word   pending_distances [$];
    int unsigned      items_sent    = 0;
    int unsigned      fail_count    = 0;
    int unsigned      idle_cycles   = 0;
    bit               hold_results  = 1'b0;
    int unsigned      tx_burst_left = 0;

    normalized_histogram_distance_top #(
        .MAX_BINS(BIN_CAP)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_first_count  (i_first_count),
        .i_second_count (i_second_count),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_distance_q16 (o_distance_q16),
        .o_no_area      (o_no_area),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic int unsigned active_bins();
        int unsigned setting;
        setting = 32'(bins_setting);
        if (setting < BINS_FLOOR) return BINS_FLOOR;
        if (setting > BIN_CAP) return BIN_CAP;
        return setting;
    endfunction

    function automatic t_distance_word area_distance(int unsigned n);
        bit [63:0] da, db, x, y, lo, hi;
        bit [63:0] min_area, max_area, min_head, max_head;
        bit [95:0] scaled;
        t_distance_word w;
        da = (first_total != 0) ? 64'(first_total) : 64'd1;
        db = (second_total != 0) ? 64'(second_total) : 64'd1;
        min_area = '0;
        max_area = '0;
        min_head = '0;
        max_head = '0;
        for (int unsigned i = 0; i < n; i++) begin
            x = 64'(first_mem[BIN_IW'(i)]) * db;
            y = 64'(second_mem[BIN_IW'(i)]) * da;
            lo = (x <= y) ? x : y;
            hi = (x <= y) ? y : x;
            if (i == 0) begin
                min_head = lo;
                max_head = hi;
            end
            min_area += lo;
            max_area += hi;
        end
        // trapezoids with a zero bin after the last one
        min_area = 2 * min_area - min_head;
        max_area = 2 * max_area - max_head;
        if (max_area == 0) begin
            w.distance = '0;
            w.no_area  = 1'b1;
        end else begin
            scaled     = 96'(max_area - min_area) << 16;
            scaled     = scaled / 96'(max_area);
            w.distance = scaled[Q_W-1:0];
            w.no_area  = 1'b0;
        end
        return w;
    endfunction

    function automatic void record_pair(bit [COUNT_W-1:0] a, bit [COUNT_W-1:0] b);
        int unsigned n;
        n = active_bins();
        if (32'(bin_pos) < BIN_CAP) begin
            first_mem[BIN_IW'(bin_pos)]  = a;
            second_mem[BIN_IW'(bin_pos)] = b;
            first_total  += 23'(a);
            second_total += 23'(b);
        end
        bin_pos++;
        if (32'(bin_pos) >= n) begin
            pending_distances.insert(pending_distances.size(), area_distance(n));
            bin_pos      = '0;
            first_total  = '0;
            second_total = '0;
        end
    endfunction

    function automatic int unsigned pick_gap();
        if ($urandom_range(0, 15) == 0) return $urandom_range(10, 60);
        return $urandom_range(1, 3);
    endfunction

    task automatic send_pair(bit [COUNT_W-1:0] a, bit [COUNT_W-1:0] b);
        int unsigned gap;
        @(negedge i_clk);
        i_in_valid     <= 1'b1;
        i_first_count  <= a;
        i_second_count <= b;
        do @(posedge i_clk); while (!o_in_ready);
        record_pair(a, b);
        items_sent++;
        if (tx_burst_left > 0) begin
            tx_burst_left--;
        end else if ($urandom_range(0, 9) == 0) begin
            tx_burst_left = $urandom_range(10, 60);
        end else if ($urandom_range(0, 2) == 0) begin
            gap = pick_gap();
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic send_pass(int unsigned n, t_fill fill);
        bit [COUNT_W-1:0] a, b;
        for (int unsigned i = 0; i < n; i++) begin
            a = COUNT_W'($urandom);
            b = COUNT_W'($urandom);
            case (fill)
                FILL_SMALL: begin
                    a = COUNT_W'($urandom_range(0, 3));
                    b = COUNT_W'($urandom_range(0, 3));
                end
                FILL_FIRST_EMPTY: a = '0;
                FILL_SECOND_EMPTY: b = '0;
                FILL_SAME: b = a;
                FILL_SPARSE: begin
                    if ($urandom_range(0, 3) != 0) a = '0;
                    if ($urandom_range(0, 3) != 0) b = '0;
                end
                default: ;
            endcase
            send_pair(a, b);
        end
    endtask

    task automatic wait_all_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_distances.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_bins(bit [CFG_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        bins_setting = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_bin_count();
        send_pass(32'(BINS_RESET), FILL_RANDOM);
        wait_all_results();
    endtask

    task automatic test_directed_cases();
        // below the floor, both histograms empty then first empty
        write_bins(8'd0);
        send_pair(16'd0, 16'd0);
        send_pair(16'd0, 16'd0);
        send_pair(16'd0, 16'd5);
        send_pair(16'd0, 16'd9);
        wait_all_results();
        write_bins(8'd1);
        send_pair(16'hFFFF, 16'd0);
        send_pair(16'd1, 16'd0);
        wait_all_results();
        // identical at full scale, then fully disjoint
        write_bins(8'd2);
        send_pair(16'hFFFF, 16'hFFFF);
        send_pair(16'hFFFF, 16'hFFFF);
        send_pair(16'hFFFF, 16'd0);
        send_pair(16'd0, 16'hFFFF);
        wait_all_results();
        write_bins(8'd3);
        send_pair(16'd1, 16'hFFFF);
        send_pair(16'hFFFF, 16'd1);
        send_pair(16'h5555, 16'hAAAA);
        wait_all_results();
    endtask

    task automatic test_backpressure();
        hold_results = 1'b1;
        repeat (4) send_pass(3, FILL_RANDOM);
        wait_all_results();
    endtask

    task automatic test_largest_passes();
        write_bins(8'd128);
        send_pass(BIN_CAP, FILL_RANDOM);
        wait_all_results();
        // above the cap
        write_bins(8'd255);
        send_pass(active_bins(), FILL_SPARSE);
        wait_all_results();
    endtask

    task automatic test_random_passes();
        bit [CFG_W-1:0] setting;
        int unsigned    passes;
        while (items_sent < RANDOM_ITEM_TARGET) begin
            case ($urandom_range(0, 7))
                0: setting = CFG_W'($urandom_range(0, 1));
                1: setting = CFG_W'($urandom_range(13, 40));
                default: setting = CFG_W'($urandom_range(2, 12));
            endcase
            write_bins(setting);
            passes = $urandom_range(1, 6);
            repeat (passes) send_pass(active_bins(), t_fill'($urandom_range(0, 5)));
            wait_all_results();
        end
    endtask

    initial begin
        int unsigned stall_left;
        int unsigned calm_left;
        stall_left = 0;
        calm_left  = 0;
        forever begin
            @(negedge i_clk);
            if (hold_results) begin
                i_out_ready <= 1'b0;
                repeat (RESULT_HOLD_CYCLES - 1) @(negedge i_clk);
                hold_results = 1'b0;
            end else if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else begin
                i_out_ready <= 1'b1;
                if (calm_left > 0) begin
                    calm_left--;
                end else if ($urandom_range(0, 9) == 0) begin
                    calm_left = $urandom_range(20, 200);
                end else if ($urandom_range(0, 3) == 0) begin
                    stall_left = pick_gap();
                end
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        t_distance_word want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_distances.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("unexpected result word: distance %0d no_area %0d",
                             o_distance_q16, o_no_area);
            end else begin
                want = pending_distances.pop_front();
                if (o_distance_q16 !== want.distance || o_no_area !== want.no_area) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("result word mismatch: expected %0d/%0d, got %0d/%0d",
                                 want.distance, want.no_area, o_distance_q16, o_no_area);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_bin_count();
        test_directed_cases();
        test_backpressure();
        test_largest_passes();
        test_random_passes();
        wait_all_results();
        repeat (END_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_distances.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
